@@ sv/trk_pkg.sv @@
`timescale 1ns / 1ps

package trk_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int LEN_BITS    = 48;
    localparam int IDX_BITS    = 5;

    localparam int S_DATA_BITS = 32;
    localparam int S_USER_BITS = 2;
    localparam int M_DATA_BITS = 112;

    localparam int USER_FIRST_SAMPLE = 0;
    localparam int USER_LAST_TRACK   = 1;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef struct packed {
        logic [LEN_BITS-1:0] best_length;
        logic [IDX_BITS-1:0] best_index;
        logic [LEN_BITS-1:0] track_length;
        logic [IDX_BITS-1:0] track_index;
    } result_t;

endpackage

@@ sv/trk_root_cell.sv @@
`timescale 1ns / 1ps

module trk_root_cell #(
    parameter int RAD_BITS  = 34,
    parameter int ROOT_BITS = 25,
    parameter int REM_BITS  = 27
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [RAD_BITS-1:0]  in_rad,
    input  logic [REM_BITS-1:0]  in_rem,
    input  logic [ROOT_BITS-1:0] in_root,
    output logic                 out_valid,
    output logic [RAD_BITS-1:0]  out_rad,
    output logic [REM_BITS-1:0]  out_rem,
    output logic [ROOT_BITS-1:0] out_root
);

    logic [REM_BITS+1:0] rem_shift;
    logic [REM_BITS+1:0] trial;
    logic [REM_BITS+1:0] diff;
    logic                fits;

    logic                 valid_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RAD_BITS-1:0]  rad_next;
    logic [REM_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_next;

    always_comb begin
        rem_shift = {in_rem, in_rad[RAD_BITS-1 -: 2]};
        trial     = {{(REM_BITS-ROOT_BITS){1'b0}}, in_root, 2'b01};
        diff      = rem_shift - trial;
        fits      = (rem_shift >= trial);
        rem_next  = fits ? diff[REM_BITS-1:0] : rem_shift[REM_BITS-1:0];
        root_next = {in_root[ROOT_BITS-2:0], fits};
        rad_next  = {in_rad[RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

@@ sv/trk_root_chain.sv @@
`timescale 1ns / 1ps

module trk_root_chain #(
    parameter int RAD_BITS = 34,
    parameter int NCELL    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [RAD_BITS-1:0] in_rad,
    output logic                out_valid,
    output logic [NCELL-1:0]    out_root
);

    localparam int REM_BITS = NCELL + 2;

    logic                valid_tap [0:NCELL];
    logic [RAD_BITS-1:0] rad_tap   [0:NCELL];
    logic [REM_BITS-1:0] rem_tap   [0:NCELL];
    logic [NCELL-1:0]    root_tap  [0:NCELL];

    assign valid_tap[0] = in_valid;
    assign rad_tap[0]   = in_rad;
    assign rem_tap[0]   = '0;
    assign root_tap[0]  = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        trk_root_cell #(
            .RAD_BITS  (RAD_BITS),
            .ROOT_BITS (NCELL),
            .REM_BITS  (REM_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_tap[i]),
            .in_rad    (rad_tap[i]),
            .in_rem    (rem_tap[i]),
            .in_root   (root_tap[i]),
            .out_valid (valid_tap[i+1]),
            .out_rad   (rad_tap[i+1]),
            .out_rem   (rem_tap[i+1]),
            .out_root  (root_tap[i+1])
        );
    end

    assign out_valid = valid_tap[NCELL];
    assign out_root  = root_tap[NCELL];

endmodule

@@ sv/track_path_length_min_finder_core.sv @@
`timescale 1ns / 1ps

// Sums the Euclidean step lengths of each track in a stream of position samples, with 8
// fraction bits and saturation at the top of the 48-bit range, and on the last sample of
// a track returns its length together with the shortest non-zero track of the set so far.
// Items are taken one at a time. A sample that opens a track only stores its position and
// clears the running length, and goes on to the finish state if it also closes the track.
// Any other sample first has its squares formed and registered, and then the root passes
// through a row of min(COORD_BITS,16) + 9 cells that each settle one result bit per cycle,
// and by the finish state if it closes a track. A finished result waits in an output
// register while the next request is taken in.
module track_path_length_min_finder_core
    import trk_pkg::*;
#(
    parameter int MAX_TRACKS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,   // pos_x, pos_y
    input  logic [S_USER_BITS-1:0] s_tuser,   // first_sample, last_track
    input  logic                   s_tlast,   // last_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // track_index, track_length, best_index,
                                              // best_length, zero padding
    output logic                   m_tlast    // set_done
);

    localparam int CW       = (COORD_BITS < COORD_WIDTH) ? COORD_BITS : COORD_WIDTH;
    localparam int TW       = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int PAIRS    = CW + 1;
    localparam int RAD_BITS = 2 * PAIRS;
    localparam int NCELL    = PAIRS + 8;
    localparam int SQ_BITS  = 2 * CW;
    localparam logic [TW-1:0] TRACK_LAST = TW'(MAX_TRACKS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       prev_x_reg, prev_x_next;
    logic [CW-1:0]       prev_y_reg, prev_y_next;
    logic [CW-1:0]       dx_reg, dx_next;
    logic [CW-1:0]       dy_reg, dy_next;
    logic [SQ_BITS-1:0]  sq_x_reg, sq_x_next;
    logic [SQ_BITS-1:0]  sq_y_reg, sq_y_next;
    logic                last_hold_reg, last_hold_next;
    logic                final_hold_reg, final_hold_next;
    logic [LEN_BITS-1:0] running_reg, running_next;
    logic [TW-1:0]       count_reg, count_next;
    logic [TW-1:0]       short_idx_reg, short_idx_next;
    logic [LEN_BITS-1:0] short_len_reg, short_len_next;
    logic                short_valid_reg, short_valid_next;
    logic                m_valid_reg, m_valid_next;
    result_t             result_reg, result_next;
    logic                set_done_reg, set_done_next;

    logic                accept;
    logic                out_free;
    logic [CW-1:0]       in_x, in_y;
    logic [SQ_BITS-1:0]  dx_wide, dy_wide;
    logic [RAD_BITS-1:0] rad_in;
    logic                chain_valid;
    logic [NCELL-1:0]    chain_root;
    logic [LEN_BITS:0]   len_sum;
    logic                take;
    logic                upd_valid;
    logic [TW-1:0]       upd_idx;
    logic [LEN_BITS-1:0] upd_len;

    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[COORD_WIDTH+CW-1:COORD_WIDTH];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign dx_wide  = {{CW{1'b0}}, dx_reg};
    assign dy_wide  = {{CW{1'b0}}, dy_reg};
    assign rad_in   = {1'b0, {1'b0, sq_x_reg} + {1'b0, sq_y_reg}};
    assign len_sum  = {1'b0, running_reg} + {{(LEN_BITS+1-NCELL){1'b0}}, chain_root};

    trk_root_chain #(
        .RAD_BITS (RAD_BITS),
        .NCELL    (NCELL)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (state_reg == ST_LAUNCH),
        .in_rad    (rad_in),
        .out_valid (chain_valid),
        .out_root  (chain_root)
    );

    always_comb begin
        take = (running_reg != '0) && (!short_valid_reg || (running_reg < short_len_reg));
        upd_valid = short_valid_reg || take;
        upd_idx   = take ? count_reg : short_idx_reg;
        upd_len   = take ? running_reg : short_len_reg;
    end

    always_comb begin
        state_next       = state_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        sq_x_next        = dx_wide * dx_wide;
        sq_y_next        = dy_wide * dy_wide;
        last_hold_next   = last_hold_reg;
        final_hold_next  = final_hold_reg;
        running_next     = running_reg;
        count_next       = count_reg;
        short_idx_next   = short_idx_reg;
        short_len_next   = short_len_reg;
        short_valid_next = short_valid_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        result_next      = result_reg;
        set_done_next    = set_done_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    prev_x_next     = in_x;
                    prev_y_next     = in_y;
                    dx_next         = (in_x >= prev_x_reg) ? in_x - prev_x_reg
                                                           : prev_x_reg - in_x;
                    dy_next         = (in_y >= prev_y_reg) ? in_y - prev_y_reg
                                                           : prev_y_reg - in_y;
                    last_hold_next  = s_tlast;
                    final_hold_next = s_tuser[USER_LAST_TRACK];
                    if (s_tuser[USER_FIRST_SAMPLE]) begin
                        running_next = '0;
                        state_next   = s_tlast ? ST_FINISH : ST_IDLE;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (chain_valid) begin
                    running_next = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];
                    state_next   = last_hold_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    result_next.track_index  = IDX_BITS'(count_reg);
                    result_next.track_length = running_reg;
                    result_next.best_index   = upd_valid ? IDX_BITS'(upd_idx) : '0;
                    result_next.best_length  = upd_valid ? upd_len : '0;
                    set_done_next            = final_hold_reg;
                    running_next             = '0;
                    if (final_hold_reg) begin
                        count_next       = '0;
                        short_idx_next   = '0;
                        short_len_next   = '0;
                        short_valid_next = 1'b0;
                    end else begin
                        count_next       = (count_reg == TRACK_LAST) ? '0 : count_reg + 1'b1;
                        short_idx_next   = upd_idx;
                        short_len_next   = upd_len;
                        short_valid_next = upd_valid;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            running_reg     <= '0;
            count_reg       <= '0;
            short_idx_reg   <= '0;
            short_len_reg   <= '0;
            short_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            running_reg     <= running_next;
            count_reg       <= count_next;
            short_idx_reg   <= short_idx_next;
            short_len_reg   <= short_len_next;
            short_valid_reg <= short_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sq_x_reg       <= sq_x_next;
        sq_y_reg       <= sq_y_next;
        last_hold_reg  <= last_hold_next;
        final_hold_reg <= final_hold_next;
        result_reg     <= result_next;
        set_done_reg   <= set_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = set_done_reg;
    assign m_tdata  = {{(M_DATA_BITS-2*(LEN_BITS+IDX_BITS)){1'b0}}, result_reg};

    a_chain_only_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid |-> (state_reg == ST_ROOT))
        else $error("Root result arrived outside the root wait state.");

    a_first_clears_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[USER_FIRST_SAMPLE]) |=> (running_reg == '0))
        else $error("Opening sample did not clear the running length.");

    a_shortest_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        short_valid_reg |-> (short_len_reg != '0))
        else $error("Shortest track holds a zero length.");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("Finished track did not reach the output register.");

endmodule

@@ verif/track_path_length_min_finder_core_tb.sv @@
`timescale 1ns / 1ps

module track_path_length_min_finder_core_tb;
    import trk_pkg::*;

    localparam int TRACK_SLOTS = 32;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 400;

    typedef struct packed {
        logic [IDX_BITS-1:0] track_index;
        logic [LEN_BITS-1:0] track_length;
        logic [IDX_BITS-1:0] best_index;
        logic [LEN_BITS-1:0] best_length;
        logic                set_done;
    } path_result_t;

    class track_length_book;
        bit [COORD_WIDTH-1:0] last_x;
        bit [COORD_WIDTH-1:0] last_y;
        bit [LEN_BITS-1:0]    open_length;
        bit [IDX_BITS-1:0]    open_track;
        bit [IDX_BITS-1:0]    best_track;
        bit [LEN_BITS-1:0]    best_length;
        bit                   best_known;
        path_result_t         awaited[$];
        int                   failures;
        int                   zero_tracks;
        int                   sets_closed;

        function bit [24:0] step_q8(bit [32:0] sq);
            longint unsigned rad;
            longint unsigned rem;
            longint unsigned root;
            longint unsigned trial;
            int k;
            rad  = longint'(sq) << 16;
            rem  = 0;
            root = 0;
            for (k = 24; k >= 0; k--) begin
                rem   = (rem << 2) | ((rad >> (2 * k)) & 64'd3);
                trial = (root << 2) | 64'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root[24:0];
        endfunction

        function void take_sample(bit [COORD_WIDTH-1:0] x, bit [COORD_WIDTH-1:0] y,
                                  bit first, bit last, bit closes_set);
            bit [COORD_WIDTH-1:0] dx;
            bit [COORD_WIDTH-1:0] dy;
            bit [32:0]            sq;
            bit [LEN_BITS:0]      sum;
            path_result_t         r;
            if (first) begin
                open_length = '0;
            end else begin
                dx  = (x >= last_x) ? x - last_x : last_x - x;
                dy  = (y >= last_y) ? y - last_y : last_y - y;
                sq  = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
                sum = {1'b0, open_length} + step_q8(sq);
                if (sum > {1'b0, LEN_MAX}) begin
                    open_length = LEN_MAX;
                end else begin
                    open_length = sum[LEN_BITS-1:0];
                end
            end
            last_x = x;
            last_y = y;
            if (!last) return;
            if (open_length != 0 && (!best_known || open_length < best_length)) begin
                best_known  = 1'b1;
                best_track  = open_track;
                best_length = open_length;
            end
            r.track_index  = open_track;
            r.track_length = open_length;
            r.best_index   = best_known ? best_track : '0;
            r.best_length  = best_known ? best_length : '0;
            r.set_done     = closes_set;
            awaited.push_back(r);
            if (open_length == 0) zero_tracks++;
            open_length = '0;
            if (closes_set) begin
                sets_closed++;
                open_track  = '0;
                best_track  = '0;
                best_length = '0;
                best_known  = 1'b0;
            end else begin
                open_track = (open_track == TRACK_SLOTS - 1) ? '0 : open_track + 1'b1;
            end
        endfunction

        function void compare_result(bit [M_DATA_BITS-1:0] data, bit done);
            path_result_t want;
            path_result_t got;
            got.track_index  = data[4:0];
            got.track_length = data[52:5];
            got.best_index   = data[57:53];
            got.best_length  = data[105:58];
            got.set_done     = done;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Result with no request waiting: track %0d length %0d",
                             got.track_index, got.track_length);
                return;
            end
            want = awaited.pop_front();
            if (got != want) begin
                failures++;
                if (failures <= 10)
                    $display("Mismatch: expected track %0d len %0d best %0d/%0d done %0b, got track %0d len %0d best %0d/%0d done %0b",
                             want.track_index, want.track_length, want.best_index,
                             want.best_length, want.set_done, got.track_index,
                             got.track_length, got.best_index, got.best_length,
                             got.set_done);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic [S_USER_BITS-1:0] s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tlast;

    track_length_book book = new();
    int samples_taken;
    int results_taken;
    int idle_cycles;
    int items_sent;
    int burst_left;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    track_path_length_min_finder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                book.take_sample(s_tdata[15:0], s_tdata[31:16], s_tuser[USER_FIRST_SAMPLE],
                                 s_tlast, s_tuser[USER_LAST_TRACK]);
                samples_taken++;
            end
            if (m_tvalid && m_tready) begin
                book.compare_result(m_tdata, m_tlast);
                results_taken++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("No request moved for %0d cycles.", IDLE_LIMIT);
                $display("track_path_length_min_finder_core regression: fail");
                $finish;
            end
        end
    end

    // The receiver stalls on its own pattern and, once, holds off long enough to fill the block.
    initial begin : receiver
        int mode;
        int len;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            if (!held && samples_taken >= 150) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            repeat (len) begin
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_tready <= 1'b0;
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic put_sample(input bit [15:0] x, input bit [15:0] y, input bit first,
                              input bit last, input bit closes_set);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= {closes_set, first};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_track(input int n, input bit closes_set);
        bit [15:0] x;
        bit [15:0] y;
        int mode;
        int i;
        mode = $urandom_range(0, 2);
        x = 16'($urandom);
        y = 16'($urandom);
        for (i = 0; i < n; i++) begin
            if (i != 0) begin
                case (mode)
                    0: begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                    end
                    1: begin
                        x = x + 16'($urandom_range(0, 32)) - 16'd16;
                        y = y + 16'($urandom_range(0, 32)) - 16'd16;
                    end
                    default: begin
                        x = {16{1'($urandom_range(0, 1))}};
                        y = {16{1'($urandom_range(0, 1))}};
                    end
                endcase
            end
            put_sample(x, y, i == 0, i == n - 1,
                       closes_set && (i == n - 1 || $urandom_range(0, 1) == 1));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (book.awaited.size() != 0);
        burst_left = 0;
    endtask

    initial begin : stimulus
        int n_tracks;
        int t;
        int len;
        int i;
        bit wrap_done;
        bit mid_drained;
        wrap_done   = 1'b0;
        mid_drained = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: continuation straight after reset, zero-length and single-sample
        // tracks, a tie, a last-track mark without a last sample, and extreme coordinates.
        put_sample(16'hFFFF, 16'hFFFF, 0, 0, 0);
        put_sample(16'hFFFF, 16'hFFFF, 0, 1, 0);
        put_sample(16'h0000, 16'h0000, 1, 1, 0);
        put_sample(16'd0, 16'd0, 1, 0, 0);
        put_sample(16'd3, 16'd4, 0, 1, 0);
        put_sample(16'd10, 16'd10, 1, 0, 0);
        put_sample(16'd13, 16'd14, 0, 1, 0);
        put_sample(16'd100, 16'd0, 1, 0, 1);
        put_sample(16'd1, 16'd0, 0, 1, 1);
        put_sample(16'd5, 16'd5, 1, 1, 0);
        put_sample(16'd5, 16'd9, 0, 1, 0);
        put_sample(16'h0000, 16'hFFFF, 1, 0, 0);
        put_sample(16'hFFFF, 16'h0000, 0, 0, 0);
        put_sample(16'hFFFF, 16'hFFFF, 0, 1, 0);
        put_sample(16'd7, 16'd7, 1, 1, 1);
        put_sample(16'd1, 16'd1, 1, 1, 1);
        put_sample(16'd0, 16'd0, 1, 0, 0);
        put_sample(16'd1, 16'd1, 0, 1, 1);

        while (items_sent < ITEM_TARGET) begin
            if (wrap_done && $urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    put_sample(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            end else begin
                if (!wrap_done || $urandom_range(0, 7) == 0) begin
                    n_tracks = $urandom_range(33, 40);
                end else begin
                    n_tracks = $urandom_range(1, 6);
                end
                wrap_done = 1'b1;
                for (t = 0; t < n_tracks; t++) begin
                    if (n_tracks > 8) begin
                        len = $urandom_range(1, 2);
                    end else begin
                        len = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 6);
                    end
                    send_track(len, t == n_tracks - 1);
                end
            end
            if (!mid_drained && items_sent >= ITEM_TARGET / 2) begin
                mid_drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d samples; %0d tracks finished over %0d closed sets, %0d of zero length.",
                 samples_taken, results_taken, book.sets_closed, book.zero_tracks);
        $display("Included a track-index wrap, a long output hold-off and a mid-run drain.");
        if (book.failures == 0 && book.awaited.size() == 0) begin
            $display("track_path_length_min_finder_core regression: pass");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", book.failures,
                     book.awaited.size());
            $display("track_path_length_min_finder_core regression: fail");
        end
        $finish;
    end

endmodule
